// ===== sv/sha_pkg.sv =====
package sha_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] hash_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LOAD,
    S_COMP,
    S_ADD,
    S_OUT
  } state_t;

  localparam int unsigned CountW = 61;
  localparam word_t PadByte = 32'h0000_0080;

  localparam hash_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t ror(input word_t x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sig0(input word_t x);
    big_sig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    big_sig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic word_t sml_sig0(input word_t x);
    sml_sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sml_sig1(input word_t x);
    sml_sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t round_k(input logic [5:0] r);
    case (r)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage

// ===== sv/sha_round.sv =====
module sha_round (
  input  sha_pkg::hash_t v,
  input  sha_pkg::word_t w,
  input  sha_pkg::word_t k,
  output sha_pkg::hash_t v_next
);
  import sha_pkg::*;

  word_t ch;
  word_t mj;
  word_t t1;
  word_t t2;

  // One compression round: a..h live in v[0]..v[7]
  always_comb begin
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1 = v[7] + big_sig1(v[4]) + ch + k + w;
    t2 = big_sig0(v[0]) + mj;
    v_next[7] = v[6];
    v_next[6] = v[5];
    v_next[5] = v[4];
    v_next[4] = v[3] + t1;
    v_next[3] = v[2];
    v_next[2] = v[1];
    v_next[1] = v[0];
    v_next[0] = t1 + t2;
  end

endmodule

// ===== sv/sha256_hash_engine.sv =====
// SHA-256 engine, one message byte per input beat.
// Input channel (in_valid/in_ready): data_byte, byte_valid, last. A beat with
// byte_valid 0 and last 0 is a no-op; last ends the message, with or without
// a byte in the same beat.
// Output channel (out_valid/out_ready): eight beats per message, digest_word
// with word_index 0..7 (0 most significant) and last_word on index 7.
// Throughput: one byte per cycle until a 64-byte block fills; the block then
// goes through the compression loop (one read setup, 64 rounds at one round
// per cycle from the block memory, one add-back), during which in_ready is low.
// After last, padding writes the remaining words of the block memory, then
// one or two compressions run (two when 56 or more bytes of the last block
// are used), and then the eight words go out.
// The output holds its beat while out_ready is low, and no new input is taken
// until the eighth word is delivered. Reset loads the initial hash values and
// clears the byte count; the block memory needs no clearing.
module sha256_hash_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           data_byte,
  input  logic                 byte_valid,
  input  logic                 last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sha_pkg::word_t       digest_word,
  output logic [2:0]           word_index,
  output logic                 last_word
);
  import sha_pkg::*;

  state_t state;
  state_t state_next;

  hash_t              hash;
  hash_t              v;
  hash_t              v_rnd;
  logic [CountW-1:0]  count;
  logic [CountW-1:0]  count_inc;
  word_t              cur_word;
  logic [5:0]         rnd;
  logic [3:0]         widx;
  logic [2:0]         oidx;
  logic               pad_pend;
  logic               padding;
  logic               pad_sec;
  word_t              sched [16];

  // Block memory
  word_t              blk_mem [16];
  word_t              rd_data;
  logic [3:0]         rd_addr;
  logic               wr_en;
  logic [3:0]         wr_addr;
  word_t              wr_data;

  logic               in_acc;
  logic               out_acc;
  logic [1:0]         lane;
  word_t              byte_word;
  logic               need2;
  logic [63:0]        bit_len;
  word_t              pad_data;
  word_t              w;
  word_t              w_sched;

  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign count_inc = count + 1'b1;
  assign lane      = count[1:0];
  assign byte_word = cur_word | (word_t'(data_byte) << {~lane, 3'b000});
  assign need2     = (count[5:0] >= 6'd56);
  assign bit_len   = {count, 3'b000};

  // Word written during padding
  always_comb begin
    pad_data = '0;
    if (pad_sec || !need2) begin
      if (widx == 4'd14) begin
        pad_data = bit_len[63:32];
      end else if (widx == 4'd15) begin
        pad_data = bit_len[31:0];
      end
    end
    if (!pad_sec && widx == count[5:2]) begin
      pad_data = cur_word | (PadByte << {~lane, 3'b000});
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (byte_valid && count[5:0] == 6'd63) begin
            state_next = S_LOAD;
          end else if (last) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (widx == 4'd15) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: state_next = S_COMP;
      S_COMP: begin
        if (rnd == 6'd63) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        if (!padding) begin
          state_next = pad_pend ? S_PAD : S_IDLE;
        end else if (need2 && !pad_sec) begin
          state_next = S_PAD;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_acc && oidx == 3'd7) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs and memory port controls
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = widx;
    wr_data   = pad_data;
    rd_addr   = rnd[3:0] + 4'd1;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        wr_en    = in_acc && byte_valid;
        wr_addr  = count[5:2];
        wr_data  = byte_word;
      end
      S_PAD:  wr_en = 1'b1;
      S_LOAD: rd_addr = '0;
      S_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  assign digest_word = hash[oidx];
  assign word_index  = oidx;
  assign last_word   = (oidx == 3'd7);

  // Block memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      blk_mem[wr_addr] <= wr_data;
    end
    rd_data <= blk_mem[rd_addr];
  end

  // Message schedule from the last sixteen words
  assign w_sched = sched[0] + sml_sig0(sched[1]) + sched[9] + sml_sig1(sched[14]);
  assign w       = (rnd < 6'd16) ? rd_data : w_sched;

  sha_round u_round (
    .v      (v),
    .w      (w),
    .k      (round_k(rnd)),
    .v_next (v_rnd)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      hash     <= InitHash;
      count    <= '0;
      cur_word <= '0;
      rnd      <= '0;
      widx     <= '0;
      oidx     <= '0;
      pad_pend <= 1'b0;
      padding  <= 1'b0;
      pad_sec  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            pad_pend <= last;
            if (byte_valid) begin
              count    <= count_inc;
              cur_word <= (lane == 2'd3) ? '0 : byte_word;
            end
            if (!(byte_valid && count[5:0] == 6'd63) && last) begin
              padding <= 1'b1;
              widx    <= byte_valid ? count_inc[5:2] : count[5:2];
            end
          end
        end
        S_PAD: widx <= widx + 4'd1;
        S_LOAD: rnd <= '0;
        S_COMP: rnd <= rnd + 6'd1;
        S_ADD: begin
          for (int i = 0; i < 8; i++) begin
            hash[i] <= hash[i] + v[i];
          end
          if (!padding) begin
            padding <= pad_pend;
            widx    <= count[5:2];
          end else if (need2 && !pad_sec) begin
            pad_sec <= 1'b1;
            widx    <= '0;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              hash     <= InitHash;
              count    <= '0;
              cur_word <= '0;
              pad_pend <= 1'b0;
              padding  <= 1'b0;
              pad_sec  <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Working variables and schedule window
  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      v <= hash;
    end else if (state == S_COMP) begin
      v <= v_rnd;
      for (int i = 0; i < 15; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[15] <= w;
    end
  end

endmodule

// ===== sv/sha_chk.sv =====
module sha_chk (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input sha_pkg::word_t       digest_word,
  input logic [2:0]           word_index,
  input logic                 last_word
);

  // Input and output never open together
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("in_ready and out_valid both high");

  // Last word flag marks index seven only
  a_lastw: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last_word does not match word_index");

  // Words come out in order
  a_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_word) |=> (out_valid && word_index == $past(word_index) + 3'd1))
    else $error("digest words out of order");

  // Stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(digest_word) && $stable(word_index)))
    else $error("stalled output beat changed");

endmodule

bind sha256_hash_engine sha_chk u_sha_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .digest_word (digest_word),
  .word_index  (word_index),
  .last_word   (last_word)
);
